[rtl/sfd_pkg.sv]
// shared types and constants for the serial frame deframer
// no dependencies; used by every module under rtl
`default_nettype none

package sfd_pkg;

  localparam logic [7:0]  START_CODE     = 8'h02;
  localparam logic [7:0]  END_CODE       = 8'h03;
  localparam logic [15:0] CRC_POLY       = 16'h1021;
  localparam int          HEADER_BYTES   = 7;
  localparam int          MAX_LEN_W      = 9;
  localparam logic [MAX_LEN_W-1:0] MAX_LENGTH_RESET = 9'd509;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_CMD,
    PH_PAYLOAD,
    PH_CRC_LO,
    PH_CRC_HI,
    PH_END
  } phase_t;

  typedef enum logic {
    ITEM_PAYLOAD = 1'b0,
    ITEM_STATUS  = 1'b1
  } item_kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CRC_ERR = 2'd1,
    ST_NO_END  = 2'd2,
    ST_BAD_LEN = 2'd3
  } frame_status_t;

  typedef struct packed {
    item_kind_t    kind;
    logic [7:0]    payload;
    logic [7:0]    command;
    logic [15:0]   length;
    frame_status_t status;
  } sfd_result_t;

endpackage

`default_nettype wire

[rtl/serial_frame_deframer_crc16.sv]
// top level of the serial frame deframer: input register, parser, result register
// depends on sfd_pkg, sfd_parser and sfd_crc16
//
// Takes one received byte per clock with no gaps while out_stall is low and returns
// payload bytes and one status item per frame (stx, little-endian length, command,
// payload, little-endian crc-16/xmodem, etx). A byte passes from the input register
// to the result register. The critical path is the eight-step byte-wide crc update
// in front of the parser state. Bytes that produce no result keep moving while a
// finished result waits on out_stall. max_length resets to 509.
`default_nettype none

module serial_frame_deframer_crc16 #(
  parameter int MAX_FRAME_BYTES = 516
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_item_kind,
  output logic [7:0]  out_payload_byte,
  output logic [7:0]  out_command,
  output logic [15:0] out_frame_length,
  output logic [1:0]  out_status,
  output logic        out_last,
  input  logic        cfg_wr_en,
  input  logic [8:0]  cfg_wr_data
);

  logic [sfd_pkg::MAX_LEN_W-1:0] max_len_r;
  logic                in_vld_r, in_vld_nxt;
  logic [7:0]          in_byte_r;
  logic                out_vld_r, out_vld_nxt;
  sfd_pkg::sfd_result_t out_res_r;
  logic                res_valid;
  sfd_pkg::sfd_result_t res;
  logic                advance;
  logic                in_take;
  logic                out_load;

  assign advance  = in_vld_r && (!res_valid || !out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;
  assign in_take  = in_valid && !in_stall;
  assign out_load = advance && res_valid;

  assign in_vld_nxt  = in_take ? 1'b1 : (advance ? 1'b0 : in_vld_r);
  assign out_vld_nxt = out_load ? 1'b1 : (out_vld_r && out_stall);

  sfd_parser #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .rx_byte    (in_byte_r),
    .max_length (max_len_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= sfd_pkg::MAX_LENGTH_RESET;
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_len_r <= cfg_wr_data;
      end
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_rx_byte;
    end
    if (out_load) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_item_kind    = out_res_r.kind;
  assign out_payload_byte = out_res_r.payload;
  assign out_command      = out_res_r.command;
  assign out_frame_length = out_res_r.length;
  assign out_status       = out_res_r.status;
  assign out_last         = (out_res_r.kind == sfd_pkg::ITEM_STATUS);

  // a waiting byte always moves on when the result register is empty
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !out_vld_r) |-> !in_stall)
    else $error("input stalled with empty result register");

  // payload items carry ok status and no payload in status items
  a_payload_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_res_r.kind == sfd_pkg::ITEM_PAYLOAD) |-> (out_status == 2'd0))
    else $error("payload item with nonzero status");

  a_status_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_res_r.kind == sfd_pkg::ITEM_STATUS) |-> (out_payload_byte == 8'h00))
    else $error("status item with nonzero payload byte");

  // a pending result is never overwritten while stalled
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_stall) |-> !out_load)
    else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

[rtl/sfd_crc16.sv]
// one-byte crc-16 update, polynomial 0x1021, msb first
// depends on sfd_pkg
`default_nettype none

module sfd_crc16 (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data_in,
  output logic [15:0] crc_out
);

  logic [15:0] crc;

  always_comb begin
    crc = crc_in ^ {data_in, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (crc[15]) begin
        crc = {crc[14:0], 1'b0} ^ sfd_pkg::CRC_POLY;
      end else begin
        crc = {crc[14:0], 1'b0};
      end
    end
    crc_out = crc;
  end

endmodule

`default_nettype wire

[rtl/sfd_parser.sv]
// frame parsing state machine: phase, length, byte count and crc state
// depends on sfd_pkg and sfd_crc16
`default_nettype none

module sfd_parser #(
  parameter int MAX_FRAME_BYTES = 516
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [7:0]           rx_byte,
  input  logic [sfd_pkg::MAX_LEN_W-1:0] max_length,
  output logic                 res_valid,
  output sfd_pkg::sfd_result_t res
);

  localparam logic [16:0] LenLimit = 17'(MAX_FRAME_BYTES - sfd_pkg::HEADER_BYTES);

  sfd_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] length_r, length_nxt;
  logic [15:0] left_r, left_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] crc_rx_r, crc_rx_nxt;
  logic [7:0]  cmd_r, cmd_nxt;

  logic [15:0] crc_upd;
  logic [15:0] len_cat;
  logic [15:0] left_dec;
  logic        len_bad;

  sfd_crc16 u_crc (
    .crc_in  (crc_r),
    .data_in (rx_byte),
    .crc_out (crc_upd)
  );

  assign len_cat  = {rx_byte, length_r[7:0]};
  assign len_bad  = (len_cat == 16'd0)
                 || (len_cat > {{(16-sfd_pkg::MAX_LEN_W){1'b0}}, max_length})
                 || ({1'b0, len_cat} > LenLimit);
  assign left_dec = (left_r != 16'd0) ? (left_r - 16'd1) : left_r;

  always_comb begin
    phase_nxt   = phase_r;
    length_nxt  = length_r;
    left_nxt    = left_r;
    crc_nxt     = crc_r;
    crc_rx_nxt  = crc_rx_r;
    cmd_nxt     = cmd_r;
    res_valid   = 1'b0;
    res.kind    = sfd_pkg::ITEM_STATUS;
    res.payload = 8'h00;
    res.command = cmd_r;
    res.length  = length_r;
    res.status  = sfd_pkg::ST_OK;
    unique case (phase_r)
      sfd_pkg::PH_HUNT: begin
        if (rx_byte == sfd_pkg::START_CODE) begin
          crc_nxt    = 16'h0000;
          length_nxt = 16'h0000;
          left_nxt   = 16'h0000;
          crc_rx_nxt = 16'h0000;
          cmd_nxt    = 8'h00;
          phase_nxt  = sfd_pkg::PH_LEN_LO;
        end
      end
      sfd_pkg::PH_LEN_LO: begin
        length_nxt = {8'h00, rx_byte};
        crc_nxt    = crc_upd;
        phase_nxt  = sfd_pkg::PH_LEN_HI;
      end
      sfd_pkg::PH_LEN_HI: begin
        length_nxt = len_cat;
        crc_nxt    = crc_upd;
        if (len_bad) begin
          phase_nxt   = sfd_pkg::PH_HUNT;
          res_valid   = 1'b1;
          res.command = 8'h00;
          res.length  = len_cat;
          res.status  = sfd_pkg::ST_BAD_LEN;
        end else begin
          phase_nxt = sfd_pkg::PH_CMD;
        end
      end
      sfd_pkg::PH_CMD: begin
        cmd_nxt   = rx_byte;
        crc_nxt   = crc_upd;
        left_nxt  = length_r - 16'd1;
        phase_nxt = (length_r != 16'd1) ? sfd_pkg::PH_PAYLOAD : sfd_pkg::PH_CRC_LO;
      end
      sfd_pkg::PH_PAYLOAD: begin
        crc_nxt  = crc_upd;
        left_nxt = left_dec;
        if (left_dec == 16'd0) begin
          phase_nxt = sfd_pkg::PH_CRC_LO;
        end
        res_valid   = 1'b1;
        res.kind    = sfd_pkg::ITEM_PAYLOAD;
        res.payload = rx_byte;
      end
      sfd_pkg::PH_CRC_LO: begin
        crc_rx_nxt = {8'h00, rx_byte};
        phase_nxt  = sfd_pkg::PH_CRC_HI;
      end
      sfd_pkg::PH_CRC_HI: begin
        crc_rx_nxt = {rx_byte, crc_rx_r[7:0]};
        phase_nxt  = sfd_pkg::PH_END;
      end
      sfd_pkg::PH_END: begin
        phase_nxt = sfd_pkg::PH_HUNT;
        res_valid = 1'b1;
        if (rx_byte != sfd_pkg::END_CODE) begin
          res.status = sfd_pkg::ST_NO_END;
        end else if (crc_rx_r != crc_r) begin
          res.status = sfd_pkg::ST_CRC_ERR;
        end else begin
          res.status = sfd_pkg::ST_OK;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= sfd_pkg::PH_HUNT;
      length_r <= 16'h0000;
      left_r   <= 16'h0000;
      crc_r    <= 16'h0000;
      crc_rx_r <= 16'h0000;
      cmd_r    <= 8'h00;
    end else if (step) begin
      phase_r  <= phase_nxt;
      length_r <= length_nxt;
      left_r   <= left_nxt;
      crc_r    <= crc_nxt;
      crc_rx_r <= crc_rx_nxt;
      cmd_r    <= cmd_nxt;
    end
  end

endmodule

`default_nettype wire
